@@ sv/dds_pkg.sv @@
// Shared types and constants for the diagonal dominance shift block.
package dds_pkg;

    localparam int DIM_W      = 7;
    localparam int OFFSET_W   = 31;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int NEWDIAG_W  = 40;
    localparam int INDEX_W    = 6;
    localparam int ENTRY_W    = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIM    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'b1;

    typedef struct packed {
        logic [INDEX_W-1:0]        row_index;
        logic [INDEX_W-1:0]        col_index;
        logic signed [ENTRY_W-1:0] entry_value;
        logic                      final_entry;
    } entry_t;

    typedef struct packed {
        logic [INDEX_W-1:0]   diag_index;
        logic [NEWDIAG_W-1:0] new_diagonal;
        logic                 last_result;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic acc;
        logic em_rd;
        logic em_sub;
        logic em_load;
        logic cnt_clr;
        logic cnt_inc;
        logic clr;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic final_flag;
        logic last_idx;
        logic out_free;
    } sts_t;

endpackage

@@ sv/dds_ctrl.sv @@
// Controller state machine: accumulate sequencing and result walk.
module dds_ctrl
    import dds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic entry_valid,
    output logic entry_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ACC    = 5'b00010,
        ST_EM_RD  = 5'b00100,
        ST_EM_SUB = 5'b01000,
        ST_EM_OUT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        entry_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                entry_ready = 1'b1;
                if (entry_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (sts.final_flag)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_EM_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EM_RD:
            begin
                cmd.em_rd  = 1'b1;
                state_next = ST_EM_SUB;
            end
            ST_EM_SUB:
            begin
                cmd.em_sub = 1'b1;
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.em_load = 1'b1;
                    if (sts.last_idx)
                    begin
                        cmd.clr    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_final_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC && sts.final_flag) |=> state_reg == ST_EM_RD)
        else $error("final word did not start the result walk");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |-> (sts.last_idx && cmd.em_load))
        else $error("stores cleared before the last result");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EM_OUT && !sts.out_free) |=> state_reg == ST_EM_OUT)
        else $error("result walk advanced while output was blocked");

endmodule

@@ sv/dds_datapath.sv @@
// Datapath: config registers, sum stores, accumulate and result arithmetic.
module dds_datapath
    import dds_pkg::*;
#(
    parameter int MAX_DIM     = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  entry_t                entry,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output result_t               result,
    output logic                  result_valid,
    input  logic                  result_ready
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int SUM_W  = VALUE_WIDTH + 6;
    localparam int RAW_W  = (VALUE_WIDTH > ENTRY_W) ? VALUE_WIDTH : ENTRY_W;
    localparam int OFFP_W = ((SUM_W > OFFSET_W) ? SUM_W : OFFSET_W) + 1;
    localparam int BEST_W = (OFFP_W > NEWDIAG_W) ? OFFP_W : NEWDIAG_W + 1;

    // configuration
    logic [DIM_W-1:0]    dim_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic [DIM_W-1:0]    n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
            off_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_DIM:    dim_reg <= cfg_data[DIM_W-1:0];
                CFG_OFFSET: off_reg <= cfg_data[OFFSET_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (dim_reg == '0)
            n_eff = DIM_W'(1);
        else if (dim_reg > DIM_W'(MAX_DIM))
            n_eff = DIM_W'(MAX_DIM);
        else
            n_eff = dim_reg;
    end

    // incoming word: magnitude and range check
    logic [RAW_W-1:0]       raw_ext;
    logic [VALUE_WIDTH-1:0] val;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic                   in_range_next;

    assign raw_ext       = RAW_W'($unsigned(entry.entry_value));
    assign val           = raw_ext[VALUE_WIDTH-1:0];
    assign mag_next      = val[VALUE_WIDTH-1] ? (~val + VALUE_WIDTH'(1)) : val;
    assign in_range_next = (DIM_W'(entry.row_index) < n_eff)
                        && (DIM_W'(entry.col_index) < n_eff);

    logic [IDX_W-1:0]       r_reg;
    logic [IDX_W-1:0]       c_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic                   in_range_reg;
    logic                   on_diag_reg;
    logic                   final_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg        <= entry.row_index[IDX_W-1:0];
            c_reg        <= entry.col_index[IDX_W-1:0];
            mag_reg      <= mag_next;
            in_range_reg <= in_range_next;
            on_diag_reg  <= (entry.row_index == entry.col_index);
            final_reg    <= entry.final_entry;
        end
    end

    // result walk counter
    logic [DIM_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.cnt_clr)
            cnt_reg <= '0;
        else if (cmd.cnt_inc)
            cnt_reg <= cnt_reg + DIM_W'(1);
    end

    // stores: one read, one write port each; valid flags give zero on unwritten rows
    logic [SUM_W-1:0]       row_mem [MAX_DIM];
    logic [SUM_W-1:0]       col_mem [MAX_DIM];
    logic [VALUE_WIDTH-1:0] diag_mem [MAX_DIM];

    logic [MAX_DIM-1:0]     row_vld_reg;
    logic [MAX_DIM-1:0]     col_vld_reg;
    logic [MAX_DIM-1:0]     diag_vld_reg;

    logic [IDX_W-1:0]       row_ra;
    logic [IDX_W-1:0]       col_ra;
    logic                   rd_en;
    logic [SUM_W-1:0]       row_rd_reg;
    logic [SUM_W-1:0]       col_rd_reg;
    logic [VALUE_WIDTH-1:0] diag_rd_reg;
    logic                   row_hit_reg;
    logic                   col_hit_reg;
    logic                   diag_hit_reg;

    logic                   acc_we;
    logic                   diag_we;
    logic [SUM_W-1:0]       row_new;
    logic [SUM_W-1:0]       col_new;

    assign rd_en  = cmd.load || cmd.em_rd;
    assign row_ra = cmd.load ? entry.row_index[IDX_W-1:0] : cnt_reg[IDX_W-1:0];
    assign col_ra = cmd.load ? entry.col_index[IDX_W-1:0] : cnt_reg[IDX_W-1:0];

    assign acc_we  = cmd.acc && in_range_reg;
    assign diag_we = acc_we && on_diag_reg;

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            row_mem[r_reg] <= row_new;
            col_mem[c_reg] <= col_new;
        end
        if (diag_we)
            diag_mem[r_reg] <= mag_reg;
        if (rd_en)
        begin
            row_rd_reg  <= row_mem[row_ra];
            col_rd_reg  <= col_mem[col_ra];
            diag_rd_reg <= diag_mem[cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg  <= '0;
            col_vld_reg  <= '0;
            diag_vld_reg <= '0;
            row_hit_reg  <= 1'b0;
            col_hit_reg  <= 1'b0;
            diag_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                row_vld_reg  <= '0;
                col_vld_reg  <= '0;
                diag_vld_reg <= '0;
            end
            else
            begin
                if (acc_we)
                begin
                    row_vld_reg[r_reg] <= 1'b1;
                    col_vld_reg[c_reg] <= 1'b1;
                end
                if (diag_we)
                    diag_vld_reg[r_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                row_hit_reg  <= row_vld_reg[row_ra];
                col_hit_reg  <= col_vld_reg[col_ra];
                diag_hit_reg <= diag_vld_reg[cnt_reg[IDX_W-1:0]];
            end
        end
    end

    // accumulate: saturating add of the magnitude
    logic [SUM_W-1:0]       row_old;
    logic [SUM_W-1:0]       col_old;
    logic [SUM_W:0]         row_sum;
    logic [SUM_W:0]         col_sum;

    assign row_old = row_hit_reg ? row_rd_reg : '0;
    assign col_old = col_hit_reg ? col_rd_reg : '0;
    assign row_sum = (SUM_W+1)'(row_old) + (SUM_W+1)'(mag_reg);
    assign col_sum = (SUM_W+1)'(col_old) + (SUM_W+1)'(mag_reg);
    assign row_new = row_sum[SUM_W] ? '1 : row_sum[SUM_W-1:0];
    assign col_new = col_sum[SUM_W] ? '1 : col_sum[SUM_W-1:0];

    // result stage 1: off-diagonal sums
    logic [VALUE_WIDTH-1:0] d_now;
    logic [SUM_W-1:0]       d_ext;
    logic [SUM_W-1:0]       rs_now;
    logic [SUM_W-1:0]       cs_now;
    logic [VALUE_WIDTH-1:0] d_reg;
    logic [SUM_W-1:0]       offr_reg;
    logic [SUM_W-1:0]       offc_reg;

    assign d_now  = diag_hit_reg ? diag_rd_reg : '0;
    assign d_ext  = SUM_W'(d_now);
    assign rs_now = row_hit_reg ? row_rd_reg : '0;
    assign cs_now = col_hit_reg ? col_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.em_sub)
        begin
            d_reg    <= d_now;
            offr_reg <= (rs_now > d_ext) ? (rs_now - d_ext) : '0;
            offc_reg <= (cs_now > d_ext) ? (cs_now - d_ext) : '0;
        end
    end

    // result stage 2: margin, maximum, saturation
    logic [SUM_W-1:0]     off_max;
    logic [OFFP_W-1:0]    off_plus;
    logic [BEST_W-1:0]    best;
    logic [NEWDIAG_W-1:0] new_diag;

    assign off_max  = (offr_reg > offc_reg) ? offr_reg : offc_reg;
    assign off_plus = OFFP_W'(off_max) + OFFP_W'(off_reg);
    assign best     = (BEST_W'(off_plus) > BEST_W'(d_reg)) ? BEST_W'(off_plus)
                                                           : BEST_W'(d_reg);
    assign new_diag = (|best[BEST_W-1:NEWDIAG_W]) ? '1 : best[NEWDIAG_W-1:0];

    // output register
    logic    result_valid_reg;
    result_t result_reg;
    logic    last_idx;

    assign last_idx = ((cnt_reg + DIM_W'(1)) == n_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.em_load)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.em_load)
        begin
            result_reg.diag_index   <= INDEX_W'(cnt_reg);
            result_reg.new_diagonal <= new_diag;
            result_reg.last_result  <= last_idx;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign sts.final_flag = final_reg;
    assign sts.last_idx   = last_idx;
    assign sts.out_free   = !result_valid_reg || result_ready;

    a_clear_flags: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |=> (row_vld_reg == '0 && col_vld_reg == '0 && diag_vld_reg == '0))
        else $error("store flags not cleared after the walk");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.em_rd |-> (cnt_reg < n_eff))
        else $error("result walk past the active dimension");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.em_load |=> result_valid_reg)
        else $error("loaded result not presented");

endmodule

@@ sv/diagonal_dominance_shift.sv @@
// Top level of the diagonal dominance shift block.
//
// Matrix entries come in on the entry channel (entry_valid / entry_ready),
// one word per entry: row, column, signed Q16.16 value and a final mark.
// Each entry is a read of the row and column sums, then the saturating add
// and write back; entry_ready is low during the write back. The word marked
// final closes the matrix: the block then walks indexes 0 to dim-1 (dim 0
// as 1, dim capped at MAX_DIM) and sends one result word each on the result
// channel (result_valid / result_ready). Each result goes through read,
// subtract and max/add in turn; no entry is taken during the walk. A stalled
// receiver holds the walk in place; the output register keeps the word until
// taken. After the last result the stores read as zero again at once
// (per-index valid flags), so no clearing pass runs. Configuration (dim,
// extra_offset) goes through the cfg channel, always ready; the user must see
// that it is written only while the block is idle; the block does not enforce it.
// Reset sets dim to 64, extra_offset to 0, and empties all stores.
module diagonal_dominance_shift
    import dds_pkg::*;
#(
    parameter int MAX_DIM     = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  entry_valid,
    output logic                  entry_ready,
    input  entry_t                entry,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic cfg_wr;

    // registers may be written at any cycle; only idle writes are meaningful
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    dds_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (entry_valid),
        .entry_ready (entry_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    dds_datapath #(
        .MAX_DIM     (MAX_DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry        (entry),
        .cfg_wr       (cfg_wr),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

@@ tb/tb_diagonal_dominance_shift.sv @@
// Self-checking testbench for diagonal_dominance_shift: random matrices vs. a dominance predictor.
module tb_diagonal_dominance_shift
    import dds_pkg::*;
();

    localparam int SPAN_MAX    = 64;          // MAX_DIM of the instance
    localparam int SUM_W       = 38;          // per-index abs sum width
    localparam int ITEM_GOAL   = 480;         // entry words before the stimulus stops
    localparam int SETTLE      = 12;          // cycles for an in-flight entry word to retire
    localparam int SQUEEZE_LEN = 400;         // long receiver hold-off, in cycles
    localparam int CYCLE_LIMIT = 20_000_000;  // watchdog

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the per-index sums, the diagonal magnitudes
    // and the two registers. Entry words update the sums as they are
    // taken; a final word turns the sums into the expected result words.
    // ------------------------------------------------------------------
    class diag_shift_board;
        logic [SUM_W-1:0]      row_sum [SPAN_MAX];
        logic [SUM_W-1:0]      col_sum [SPAN_MAX];
        logic [ENTRY_W-1:0]    diag_mag [SPAN_MAX];
        logic [DIM_W-1:0]      dim_reg;
        logic [OFFSET_W-1:0]   margin;
        result_t               expected_diags [$];
        int                    errors;

        function void wipe();
            for (int i = 0; i < SPAN_MAX; i++)
            begin
                row_sum[i]  = '0;
                col_sum[i]  = '0;
                diag_mag[i] = '0;
            end
        endfunction

        function void reset_state();
            dim_reg = DIM_RESET;
            margin  = '0;
            errors  = 0;
            wipe();
        endfunction

        // dim 0 behaves as 1, anything above the store depth as the depth
        function int unsigned span();
            if (dim_reg == 0)
                return 1;
            if (dim_reg > SPAN_MAX)
                return SPAN_MAX;
            return 32'(dim_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DIM)
                dim_reg = data[DIM_W-1:0];
            else if (idx == CFG_OFFSET)
                margin = data[OFFSET_W-1:0];
        endfunction

        function logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] acc, logic [ENTRY_W-1:0] mag);
            logic [SUM_W:0] s;
            s = {1'b0, acc} + (SUM_W+1)'(mag);
            return s[SUM_W] ? '1 : s[SUM_W-1:0];
        endfunction

        function logic [NEWDIAG_W-1:0] off_plus(logic [SUM_W-1:0] sum, logic [ENTRY_W-1:0] d);
            logic [SUM_W-1:0]     off;
            logic [NEWDIAG_W-1:0] total;
            off   = (sum > SUM_W'(d)) ? sum - SUM_W'(d) : '0;
            total = NEWDIAG_W'(off) + NEWDIAG_W'(margin);
            return total;
        endfunction

        function void take_entry(entry_t w);
            int unsigned          n;
            logic [ENTRY_W-1:0]   raw;
            logic [ENTRY_W-1:0]   mag;
            logic [NEWDIAG_W-1:0] best;
            logic [NEWDIAG_W-1:0] alt;
            result_t              r;
            n   = span();
            raw = w.entry_value;
            // the most negative value keeps magnitude 2^31, exact
            mag = raw[ENTRY_W-1] ? (~raw + ENTRY_W'(1)) : raw;
            if (w.row_index < n && w.col_index < n)
            begin
                row_sum[w.row_index] = sat_add(row_sum[w.row_index], mag);
                col_sum[w.col_index] = sat_add(col_sum[w.col_index], mag);
                if (w.row_index == w.col_index)
                    diag_mag[w.row_index] = mag;
            end
            if (!w.final_entry)
                return;
            for (int i = 0; i < n; i++)
            begin
                best = NEWDIAG_W'(diag_mag[i]);
                alt  = off_plus(row_sum[i], diag_mag[i]);
                if (alt > best)
                    best = alt;
                alt = off_plus(col_sum[i], diag_mag[i]);
                if (alt > best)
                    best = alt;
                r.diag_index   = i[INDEX_W-1:0];
                r.new_diagonal = best;
                r.last_result  = (i == n - 1);
                expected_diags.push_back(r);
            end
            wipe();
        endfunction

        function void check_diag(result_t got);
            result_t want;
            if (expected_diags.size() == 0)
            begin
                $display("%0t: unexpected result word idx=%0d diag=%h last=%b",
                         $time, got.diag_index, got.new_diagonal, got.last_result);
                errors++;
                return;
            end
            want = expected_diags.pop_front();
            if (got.diag_index !== want.diag_index)
            begin
                $display("%0t: diag_index expected %0d actual %0d",
                         $time, want.diag_index, got.diag_index);
                errors++;
            end
            if (got.new_diagonal !== want.new_diagonal)
            begin
                $display("%0t: new_diagonal[%0d] expected %h actual %h",
                         $time, want.diag_index, want.new_diagonal, got.new_diagonal);
                errors++;
            end
            if (got.last_result !== want.last_result)
            begin
                $display("%0t: last_result[%0d] expected %b actual %b",
                         $time, want.diag_index, want.last_result, got.last_result);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_diags.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its wires
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  entry_valid;
    logic                  entry_ready;
    entry_t                entry;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    diagonal_dominance_shift dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (entry_valid),
        .entry_ready  (entry_ready),
        .entry        (entry),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    diag_shift_board board;

    bit          send_idle_on;   // sender inserts gaps in this phase
    bit          recv_idle_on;   // receiver stalls in this phase
    bit          squeeze_req;    // ask the receiver for one long hold-off
    int unsigned sent_items;
    int unsigned cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Gap length: mostly a few cycles, now and then a long one.
    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready is driven at the falling edge, words are checked
    // at the rising edge where valid and ready are both high.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        stall_left   = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_req)
            begin
                // long hold-off: the walk stops, then the entry side backs up
                squeeze_req = 1'b0;
                stall_left  = SQUEEZE_LEN;
            end
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else if (recv_idle_on && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                stall_left = draw_gap() - 1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_diag(result);
    end

    // ------------------------------------------------------------------
    // Entry side. Every task starts and ends at a falling edge; valid is
    // only lowered when a gap follows, so back-to-back words keep it high.
    // ------------------------------------------------------------------
    task automatic send_entry(input logic [INDEX_W-1:0] r, input logic [INDEX_W-1:0] c,
                              input logic [ENTRY_W-1:0] v, input logic fin);
        entry_t      w;
        int unsigned gap;
        w.row_index   = r;
        w.col_index   = c;
        w.entry_value = v;
        w.final_entry = fin;
        gap = (send_idle_on && $urandom_range(0, 3) == 0) ? draw_gap() : 0;
        if (gap > 0)
        begin
            entry_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        entry_valid <= 1'b1;
        entry       <= w;
        do @(posedge clk); while (!entry_ready);
        board.take_entry(w);
        sent_items++;
        @(negedge clk);
    endtask

    // Both registers in one burst; valid stays up across the two words.
    task automatic apply_setup(input logic [CFG_DATA_W-1:0] dim_word,
                               input logic [CFG_DATA_W-1:0] off_word);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DIM;
        cfg_data  <= dim_word;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(CFG_DIM, dim_word);
        @(negedge clk);
        cfg_index <= CFG_OFFSET;
        cfg_data  <= off_word;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(CFG_OFFSET, off_word);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every expected word, then let a trailing non-final entry retire.
    task automatic drain();
        entry_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [ENTRY_W-1:0] pick_value();
        logic [ENTRY_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = '0;
            3: v = '1;
            4, 5, 6:
            begin
                // a few units of Q16.16, either sign
                v = $urandom_range(0, 32'h3_FFFF);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: return DIM_W'($urandom_range(1, 8));
            9, 10, 11:                return DIM_W'($urandom_range(9, 63));
            12, 13:                   return 7'd64;
            14, 15:                   return 7'd0;
            16, 17:                   return DIM_W'($urandom_range(65, 127));
            18:                       return 7'd1;
            default:                  return 7'd127;
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_offset();
        case ($urandom_range(0, 11))
            0, 1, 2, 3:  return '0;
            4, 5:        return '1;
            6, 7, 8, 9:  return OFFSET_W'($urandom_range(0, 32'h3_FFFF));
            default:     return OFFSET_W'($urandom());
        endcase
    endfunction

    // Register words with junk in the bits above each field.
    task automatic random_setup(input logic [DIM_W-1:0] d, input logic [OFFSET_W-1:0] o);
        logic [CFG_DATA_W-1:0] dw;
        logic [CFG_DATA_W-1:0] ow;
        dw = $urandom();
        ow = $urandom();
        dw[DIM_W-1:0]    = d;
        ow[OFFSET_W-1:0] = o;
        apply_setup(dw, ow);
    endtask

    function automatic int unsigned pick_index(int unsigned n);
        if (n < SPAN_MAX && $urandom_range(0, 9) == 0)
            return $urandom_range(n, SPAN_MAX - 1);   // outside the matrix
        return $urandom_range(0, n - 1);
    endfunction

    // One matrix: for small sizes sometimes dense row-major, otherwise a sparse
    // scatter with diagonal hits, repeats and stray indexes.
    task automatic send_matrix();
        int unsigned n;
        int unsigned cnt;
        int unsigned r;
        int unsigned c;
        n = board.span();
        if (n <= 6 && $urandom_range(0, 3) == 0)
        begin
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    send_entry(i[INDEX_W-1:0], j[INDEX_W-1:0], pick_value(),
                               (i == n - 1) && (j == n - 1));
        end
        else
        begin
            cnt = $urandom_range(1, 12);
            for (int k = 0; k < cnt; k++)
            begin
                r = pick_index(n);
                c = ($urandom_range(0, 4) == 0) ? r : pick_index(n);
                send_entry(r[INDEX_W-1:0], c[INDEX_W-1:0], pick_value(), k == cnt - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned phase;
        board = new;
        board.reset_state();
        rst_n        = 1'b0;
        entry_valid  = 1'b0;
        entry        = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_DIM;
        cfg_data     = '0;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        squeeze_req  = 1'b0;
        sent_items   = 0;
        cycles       = 0;
        phase        = 0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings (dim 64, no margin): corner values, corner
        // indexes, a repeated diagonal, final word off the diagonal.
        send_entry(6'd0,  6'd0,  32'h7FFF_FFFF, 1'b0);
        send_entry(6'd63, 6'd63, 32'h8000_0000, 1'b0);
        send_entry(6'd0,  6'd63, 32'hFFFF_FFFF, 1'b0);
        send_entry(6'd63, 6'd0,  32'h0000_0001, 1'b0);
        send_entry(6'd5,  6'd5,  32'h0001_0000, 1'b0);
        send_entry(6'd5,  6'd5,  32'hFFFD_0000, 1'b0);
        send_entry(6'd5,  6'd9,  32'h0002_8000, 1'b0);
        send_entry(6'd42, 6'd21, 32'h5555_5555, 1'b0);
        send_entry(6'd21, 6'd42, 32'hAAAA_AAAA, 1'b1);
        drain();

        // dim 3 with the largest margin; stray row and column are dropped,
        // and a final mark on a stray word still emits.
        apply_setup(32'hFFFF_FF83, 32'hFFFF_FFFF);
        send_entry(6'd1,  6'd1,  32'h0000_8000, 1'b0);
        send_entry(6'd2,  6'd0,  32'hC000_0000, 1'b0);
        send_entry(6'd5,  6'd1,  32'h7FFF_FFFF, 1'b0);
        send_entry(6'd1,  6'd40, 32'h1234_5678, 1'b0);
        send_entry(6'd63, 6'd63, 32'h0F0F_0F0F, 1'b1);
        drain();

        // dim 0 acts as a 1x1 matrix
        apply_setup(32'h0000_0000, 32'h0001_0000);
        send_entry(6'd0, 6'd0, 32'hFFFF_FFFB, 1'b0);
        send_entry(6'd0, 6'd1, 32'h0000_1000, 1'b0);
        send_entry(6'd0, 6'd0, 32'h0000_0003, 1'b1);
        drain();

        // dim above the depth acts as the depth
        apply_setup(32'h0000_007F, 32'h0000_0001);
        send_entry(6'd62, 6'd63, 32'h8000_0000, 1'b1);
        drain();

        // Random phases: new settings each time, several matrices back to
        // back so the sender keeps offering words while results drain.
        while (sent_items < ITEM_GOAL)
        begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 2)
            begin
                random_setup(7'd8, pick_offset());
                squeeze_req = 1'b1;
                repeat (4) send_matrix();
            end
            else if (phase == 4)
            begin
                // pile the most negative value into one row and column
                // until both sums saturate
                random_setup(7'd2, pick_offset());
                repeat (130) send_entry(6'd0, 6'd1, 32'h8000_0000, 1'b0);
                send_entry(6'd1, 6'd1, pick_value(), 1'b1);
            end
            else
            begin
                random_setup(pick_dim(), pick_offset());
                repeat ($urandom_range(2, 5)) send_matrix();
            end
            drain();
            phase++;
        end

        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
